### src/hpte_pkg.sv
package hpte_pkg;

  localparam int GROUP_COUNT = 1024;
  localparam int SLOTS_PER_GROUP = 8;

  localparam int VSID_W = 24;
  localparam int PAGE_W = 16;
  localparam int HASH_W = 19;
  localparam int API_SHIFT = 10;
  localparam int API_W = PAGE_W - API_SHIFT;
  localparam int RPN_W = 20;
  localparam int WIMG_W = 4;
  localparam int PP_W = 2;
  localparam int GROUP_OUT_W = 10;
  localparam int SLOT_OUT_W = 3;
  localparam int RPN_VSID_BITS = RPN_W - PAGE_W;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_MAP    = 2'd1;
  localparam logic [1:0] OP_UNMAP  = 2'd2;
  localparam logic [1:0] OP_CHANGE = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOT_MAP  = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // One stored entry: valid, h, vsid, api, rpn, wimg, pp (58 bits).
  typedef struct packed {
    logic              valid;
    logic              h;
    logic [VSID_W-1:0] vsid;
    logic [API_W-1:0]  api;
    logic [RPN_W-1:0]  rpn;
    logic [WIMG_W-1:0] wimg;
    logic [PP_W-1:0]   pp;
  } pte_t;

  localparam int PTE_W = $bits(pte_t);

  // A request as it travels from the front part to the back part.
  typedef struct packed {
    logic [1:0]        op;
    logic [VSID_W-1:0] vsid;
    logic [PAGE_W-1:0] page_index;
    logic [WIMG_W-1:0] wimg;
    logic [PP_W-1:0]   pp;
    logic              wimg_update;
    logic              pp_update;
    logic [HASH_W-1:0] hash;
  } req_t;

  typedef struct packed {
    logic [1:0]             status;
    logic [GROUP_OUT_W-1:0] group_index;
    logic [SLOT_OUT_W-1:0]  slot_in_group;
    logic                   secondary_hit;
    logic [RPN_W-1:0]       real_page;
    logic [WIMG_W-1:0]      wimg;
    logic [PP_W-1:0]        pp;
  } rsp_t;

endpackage

### src/hashed_page_table_engine_unit.sv
// The back part handles one request at a time and takes the next only after the
// result beat has been taken; its pace is set by the single read port of the
// entry table, which is scanned one slot per cycle.
// Reset: synchronous; afterwards a clearing pass over all GROUP_COUNT * SLOTS_PER_GROUP
// entries zeroes the table, during which in_stall stays high.
module hashed_page_table_engine_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          op,
  input  logic [hpte_pkg::VSID_W-1:0]         vsid,
  input  logic [hpte_pkg::PAGE_W-1:0]         page_index,
  input  logic [hpte_pkg::WIMG_W-1:0]         wimg_in,
  input  logic [hpte_pkg::PP_W-1:0]           pp_in,
  input  logic                                wimg_update,
  input  logic                                pp_update,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic [hpte_pkg::GROUP_OUT_W-1:0]    group_index,
  output logic [hpte_pkg::SLOT_OUT_W-1:0]     slot_in_group,
  output logic                                secondary_hit,
  output logic [hpte_pkg::RPN_W-1:0]          real_page,
  output logic [hpte_pkg::WIMG_W-1:0]         wimg_out,
  output logic [hpte_pkg::PP_W-1:0]           pp_out
);
  import hpte_pkg::*;

  // The front part latches each beat into a two-deep queue and computes the
  // primary hash; the back part scans both groups, one slot per cycle, then
  // writes back at most one entry and registers the result.
  logic clearing;
  logic q_valid;
  logic q_take;
  req_t q_req;
  rsp_t rsp;

  hpte_front u_front (
    .clk         (clk),
    .rst         (rst),
    .valid       (in_valid),
    .stall       (in_stall),
    .op          (op),
    .vsid        (vsid),
    .page_index  (page_index),
    .wimg_in     (wimg_in),
    .pp_in       (pp_in),
    .wimg_update (wimg_update),
    .pp_update   (pp_update),
    .blocked     (clearing),
    .q_valid     (q_valid),
    .q_req       (q_req),
    .q_take      (q_take)
  );

  hpte_back u_back (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .q_valid   (q_valid),
    .q_req     (q_req),
    .q_take    (q_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (rsp)
  );

  assign status        = rsp.status;
  assign group_index   = rsp.group_index;
  assign slot_in_group = rsp.slot_in_group;
  assign secondary_hit = rsp.secondary_hit;
  assign real_page     = rsp.real_page;
  assign wimg_out      = rsp.wimg;
  assign pp_out        = rsp.pp;
endmodule

### src/hpte_ram.sv
module hpte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### src/hpte_front.sv
module hpte_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid,
  output logic                          stall,
  input  logic [1:0]                    op,
  input  logic [hpte_pkg::VSID_W-1:0]   vsid,
  input  logic [hpte_pkg::PAGE_W-1:0]   page_index,
  input  logic [hpte_pkg::WIMG_W-1:0]   wimg_in,
  input  logic [hpte_pkg::PP_W-1:0]     pp_in,
  input  logic                          wimg_update,
  input  logic                          pp_update,
  input  logic                          blocked,
  output logic                          q_valid,
  output hpte_pkg::req_t                q_req,
  input  logic                          q_take
);
  import hpte_pkg::*;

  // Two-entry queue between the front and back parts.
  req_t        slot [2];
  logic        rd_ptr;
  logic        wr_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;
  req_t        incoming;

  always_comb begin
    incoming.op          = op;
    incoming.vsid        = vsid;
    incoming.page_index  = page_index;
    incoming.wimg        = wimg_in;
    incoming.pp          = pp_in;
    incoming.wimg_update = wimg_update;
    incoming.pp_update   = pp_update;
    incoming.hash        = vsid[HASH_W-1:0] ^ {{(HASH_W-PAGE_W){1'b0}}, page_index};
  end

  assign stall   = blocked || (count == 2'd2);
  assign push    = valid && !stall;
  assign pop     = q_take && (count != 2'd0);
  assign q_valid = (count != 2'd0);
  assign q_req   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### src/hpte_back.sv
module hpte_back (
  input  logic           clk,
  input  logic           rst,
  output logic           clearing,
  input  logic           q_valid,
  input  hpte_pkg::req_t q_req,
  output logic           q_take,
  output logic           out_valid,
  input  logic           out_stall,
  output hpte_pkg::rsp_t out_rsp
);
  import hpte_pkg::*;

  localparam int DEPTH  = GROUP_COUNT * SLOTS_PER_GROUP;
  localparam int AW     = $clog2(DEPTH);
  localparam int GW     = $clog2(GROUP_COUNT);
  localparam int SW     = $clog2(SLOTS_PER_GROUP);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS_PER_GROUP - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]      state;
  logic [AW-1:0]   clr_addr;
  req_t            req;
  logic            pass;        // 0 primary, 1 secondary group
  logic [SW-1:0]   slot_rd;     // slot whose read is issued
  logic            rd_pend;     // rdata holds valid read data for slot_dat
  logic [SW-1:0]   slot_dat;    // slot that rdata belongs to
  logic            pass_dat;
  logic            hit;
  logic [AW-1:0]   hit_addr;
  logic            hit_sec;
  pte_t            hit_pte;
  logic            free_ok;
  logic [AW-1:0]   free_addr;
  logic            free_sec;
  logic [GW-1:0]   grp_p;
  logic [GW-1:0]   grp_s;
  logic [GW-1:0]   grp_rd;
  logic [GW-1:0]   grp_dat;
  logic [HASH_W-1:0] hash_s;
  logic            we;
  logic [AW-1:0]   waddr;
  pte_t            wdata;
  logic [AW-1:0]   raddr;
  logic [PTE_W-1:0] rdata_raw;
  pte_t            rdata;
  logic            match;
  logic            scan_done;
  rsp_t            out_rsp_next;

  assign hash_s = ~req.hash;
  assign grp_p  = req.hash[GW-1:0];
  assign grp_s  = hash_s[GW-1:0];

  assign grp_rd  = pass ? grp_s : grp_p;
  assign raddr   = (state == S_CLEAR) ? clr_addr
                 : AW'({grp_rd, slot_rd});
  assign rdata   = pte_t'(rdata_raw);
  assign grp_dat = pass_dat ? grp_s : grp_p;

  hpte_ram #(.WIDTH(PTE_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign match = rdata.valid && (rdata.vsid == req.vsid) &&
                 (rdata.api == req.page_index[PAGE_W-1:API_SHIFT]) &&
                 (rdata.h == pass_dat);
  assign scan_done = rd_pend && pass_dat && (slot_dat == LAST_SLOT);
  assign clearing  = (state == S_CLEAR);
  assign q_take    = (state == S_IDLE) && q_valid;

  always_comb begin
    we    = 1'b0;
    waddr = hit_addr;
    wdata = hit_pte;
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (state == S_WRITE) begin
      unique case (req.op)
        OP_MAP: begin
          we          = !hit && free_ok;
          waddr       = free_addr;
          wdata.valid = 1'b1;
          wdata.h     = free_sec;
          wdata.vsid  = req.vsid;
          wdata.api   = req.page_index[PAGE_W-1:API_SHIFT];
          wdata.rpn   = {req.vsid[RPN_VSID_BITS-1:0], req.page_index};
          wdata.wimg  = req.wimg;
          wdata.pp    = req.pp;
        end
        OP_UNMAP: begin
          we          = hit;
          wdata.valid = 1'b0;
        end
        OP_CHANGE: begin
          we = hit;
          if (req.wimg_update) wdata.wimg = req.wimg;
          if (req.pp_update) wdata.pp = req.pp;
        end
        default: we = 1'b0;
      endcase
    end
  end

  // Result of the request, registered on the write-back cycle.
  always_comb begin
    out_rsp_next = '0;
    if (req.op == OP_MAP && !hit) begin
      if (free_ok) begin
        out_rsp_next.status        = ST_OK;
        out_rsp_next.group_index   = GROUP_OUT_W'(free_addr >> SW);
        out_rsp_next.slot_in_group = SLOT_OUT_W'(free_addr[SW-1:0]);
        out_rsp_next.secondary_hit = free_sec;
        out_rsp_next.real_page     = wdata.rpn;
        out_rsp_next.wimg          = wdata.wimg;
        out_rsp_next.pp            = wdata.pp;
      end else begin
        out_rsp_next.status = ST_FULL;
      end
    end else if (!hit) begin
      out_rsp_next.status = ST_NOT_MAP;
    end else begin
      out_rsp_next.status        = ST_OK;
      out_rsp_next.group_index   = GROUP_OUT_W'(hit_addr >> SW);
      out_rsp_next.slot_in_group = SLOT_OUT_W'(hit_addr[SW-1:0]);
      out_rsp_next.secondary_hit = hit_sec;
      out_rsp_next.real_page     = hit_pte.rpn;
      out_rsp_next.wimg          = (req.op == OP_CHANGE && req.wimg_update) ? req.wimg
                                                                            : hit_pte.wimg;
      out_rsp_next.pp            = (req.op == OP_CHANGE && req.pp_update) ? req.pp
                                                                          : hit_pte.pp;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      req <= q_req;
    end
    if (rd_pend && match && !hit) begin
      hit_addr <= AW'({grp_dat, slot_dat});
      hit_sec  <= pass_dat;
      hit_pte  <= rdata;
    end
    if (rd_pend && !rdata.valid && !free_ok) begin
      free_addr <= AW'({grp_dat, slot_dat});
      free_sec  <= pass_dat;
    end
    if (state == S_WRITE) begin
      out_rsp <= out_rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      pass      <= 1'b0;
      slot_rd   <= '0;
      rd_pend   <= 1'b0;
      slot_dat  <= '0;
      pass_dat  <= 1'b0;
      hit       <= 1'b0;
      free_ok   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            state   <= S_SCAN;
            pass    <= 1'b0;
            slot_rd <= '0;
            rd_pend <= 1'b0;
            hit     <= 1'b0;
            free_ok <= 1'b0;
          end
        end
        S_SCAN: begin
          // Issue one slot read per cycle; the data is checked in the cycle after.
          // The last secondary slot, too, is checked in the cycle after its read.
          rd_pend  <= !scan_done;
          slot_dat <= slot_rd;
          pass_dat <= pass;
          if (slot_rd == LAST_SLOT) begin
            pass    <= 1'b1;
            slot_rd <= '0;
          end else begin
            slot_rd <= slot_rd + SW'(1);
          end
          if (rd_pend && match) hit <= 1'b1;
          if (rd_pend && !rdata.valid) free_ok <= 1'b1;
          if (scan_done) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          out_valid <= 1'b1;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            if (out_valid) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
